// File: sv/tle_pkg.sv
// tle_pkg: shared types and constants for the terminal line editor.
// Holds the transfer payload structs, result kind codes, byte constants
// and the controller/datapath command and status structs. No dependencies.
package tle_pkg;

  // Default line store depth
  localparam int TLE_MAX_LINE = 32;

  // Result kind codes
  localparam logic [2:0] K_NEWLINE  = 3'd0;
  localparam logic [2:0] K_ECHO     = 3'd1;
  localparam logic [2:0] K_ERASE    = 3'd2;
  localparam logic [2:0] K_LINECHAR = 3'd3;
  localparam logic [2:0] K_PROMPT   = 3'd4;
  localparam logic [2:0] K_STOPPED  = 3'd5;

  // Request type codes
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_DONE = 1'b1;

  // Received byte constants
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;
  localparam logic [7:0] CH_FINAL_LO = 8'h40;
  localparam logic [7:0] CH_FINAL_HI = 8'h7E;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_UPPER_O  = 8'h4F;
  localparam logic [7:0] CH_LOWER_Q  = 8'h71;
  localparam logic [7:0] CH_UPPER_Q  = 8'h51;

  // Input item
  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic       enter_stream;
  } tle_in_t;

  // Result item
  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] char_out;
    logic       last;
  } tle_out_t;

  // Result sequence that one accepted item calls for
  typedef enum logic [2:0] {
    PL_NONE,
    PL_ECHO,
    PL_ERASE,
    PL_PROMPT,
    PL_NL_PROMPT,
    PL_NL_DELIV,
    PL_NL_STOP
  } tle_plan_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ECHO,
    S_ERASE,
    S_PROMPT,
    S_NL_PROMPT,
    S_NL_DELIV,
    S_NL_STOP,
    S_STOPPED,
    S_CHAR_RD,
    S_CHAR
  } tle_state_t;

  // Controller to datapath
  typedef struct packed {
    logic       take;     // input transfer this cycle
    logic       emit;     // load a result when the output register is free
    logic [2:0] kind;
    logic       last;
    logic       rd;       // read the line store at the delivery index
    logic       advance;  // step the delivery index
  } tle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    tle_plan_t plan;
    logic      out_free;
    logic      last_char;
  } tle_stat_t;

endpackage

// File: sv/terminal_line_editor.sv
// Channel | Ports                          | Carries
// input   | in_valid, in_stall, in_data    | tle_in_t: received byte or command done
// output  | out_valid, out_stall, out_data | tle_out_t: kind, char_out, last
//
// One item at a time. After a transfer, each result is loaded into the
// output register, where out_stall can hold it.
// A line end that delivers N stored characters sends a newline, then each
// character after one registered read of the line store.
// Reset (rst_n low, synchronous) clears editing state and holds in_stall
// high; the line store is not cleared. out_stall holds the output register
// and pauses the sequence.
//
// terminal_line_editor: top level; joins tle_ctrl and tle_dp.
// Depends on tle_pkg, tle_ctrl, tle_dp.
module terminal_line_editor import tle_pkg::*; #(
  parameter int MAX_LINE = TLE_MAX_LINE
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tle_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tle_out_t out_data
);

  tle_cmd_t  cmd;
  tle_stat_t stat;

  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tle_dp #(
    .MAX_LINE (MAX_LINE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: sv/tle_ctrl.sv
// tle_ctrl: sequencing state machine of the terminal line editor.
// Depends on tle_pkg; drives tle_dp through tle_cmd_t and reads tle_stat_t.
module tle_ctrl import tle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tle_stat_t stat,
  output tle_cmd_t  cmd
);

  tle_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    cmd         = '0;
    cmd.kind    = K_NEWLINE;
    case (state_r)
      // Take an item; hold off input while reset is asserted
      S_IDLE: begin
        in_stall = !rst_n;
        cmd.take = in_valid && rst_n;
        if (in_valid && rst_n) begin
          case (stat.plan)
            PL_ECHO:      state_nxt = S_ECHO;
            PL_ERASE:     state_nxt = S_ERASE;
            PL_PROMPT:    state_nxt = S_PROMPT;
            PL_NL_PROMPT: state_nxt = S_NL_PROMPT;
            PL_NL_DELIV:  state_nxt = S_NL_DELIV;
            PL_NL_STOP:   state_nxt = S_NL_STOP;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_ECHO: begin
        cmd.emit = 1'b1;
        cmd.kind = K_ECHO;
        cmd.last = 1'b1;
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_ERASE: begin
        cmd.emit = 1'b1;
        cmd.kind = K_ERASE;
        cmd.last = 1'b1;
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_PROMPT: begin
        cmd.emit = 1'b1;
        cmd.kind = K_PROMPT;
        cmd.last = 1'b1;
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_NL_PROMPT: begin
        cmd.emit = 1'b1;
        cmd.kind = K_NEWLINE;
        if (stat.out_free) state_nxt = S_PROMPT;
      end
      S_NL_DELIV: begin
        cmd.emit = 1'b1;
        cmd.kind = K_NEWLINE;
        if (stat.out_free) state_nxt = S_CHAR_RD;
      end
      S_NL_STOP: begin
        cmd.emit = 1'b1;
        cmd.kind = K_NEWLINE;
        if (stat.out_free) state_nxt = S_STOPPED;
      end
      S_STOPPED: begin
        cmd.emit = 1'b1;
        cmd.kind = K_STOPPED;
        if (stat.out_free) state_nxt = S_PROMPT;
      end
      // Fetch the next stored character
      S_CHAR_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHAR;
      end
      // Send it, then fetch again or finish
      S_CHAR: begin
        cmd.emit = 1'b1;
        cmd.kind = K_LINECHAR;
        cmd.last = stat.last_char;
        if (stat.out_free) begin
          cmd.advance = 1'b1;
          state_nxt   = stat.last_char ? S_IDLE : S_CHAR_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: sv/tle_dp.sv
// tle_dp: datapath of the terminal line editor: editing state, escape
// filter, line store memory, delivery index and output register.
// Depends on tle_pkg; controlled by tle_ctrl.
module tle_dp import tle_pkg::*; #(
  parameter int MAX_LINE = TLE_MAX_LINE
) (
  input  logic      clk,
  input  logic      rst_n,
  input  tle_in_t   in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output tle_out_t  out_data,
  input  tle_cmd_t  cmd,
  output tle_stat_t stat
);

  localparam int LEN_W = $clog2(MAX_LINE + 1);
  localparam int IDX_W = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

  // Editing state
  logic             stream_r,  stream_nxt;
  logic             esc_r,     esc_nxt;
  logic             br_r,      br_nxt;
  logic             prev_cr_r, prev_cr_nxt;
  logic             dropped_r, dropped_nxt;
  logic             await_r,   await_nxt;
  logic [LEN_W-1:0] len_r,     len_nxt;
  logic [LEN_W-1:0] dlen_r,    dlen_nxt;
  logic [LEN_W-1:0] rd_idx_r;
  logic [6:0]       echo_ch_r;
  logic [6:0]       rdata_r;
  logic             out_valid_r;
  tle_out_t         out_r;

  logic [6:0]       line_mem [MAX_LINE];
  logic [7:0]       b;
  logic             consumed;
  logic             wr_en;
  logic             out_free;
  tle_plan_t        plan;

  assign b        = in_data.rx_byte;
  assign out_free = !out_valid_r || !out_stall;

  // Decode one item against the current state
  always_comb begin
    stream_nxt  = stream_r;
    esc_nxt     = esc_r;
    br_nxt      = br_r;
    prev_cr_nxt = prev_cr_r;
    dropped_nxt = dropped_r;
    await_nxt   = await_r;
    len_nxt     = len_r;
    dlen_nxt    = dlen_r;
    plan        = PL_NONE;
    wr_en       = 1'b0;
    consumed    = 1'b0;
    if (in_data.req_type == REQ_DONE) begin
      if (await_r) begin
        await_nxt = 1'b0;
        if (in_data.enter_stream) begin
          stream_nxt = 1'b1;
          esc_nxt    = 1'b0;
          br_nxt     = 1'b0;
        end else begin
          plan = PL_PROMPT;
        end
      end
    end else if (!await_r) begin
      // Escape filter
      if (!esc_r) begin
        if (b == CH_ESC) begin
          esc_nxt  = 1'b1;
          br_nxt   = 1'b0;
          consumed = 1'b1;
        end
      end else if (!br_r) begin
        if (b == CH_LBRACKET || b == CH_UPPER_O) begin
          br_nxt   = 1'b1;
          consumed = 1'b1;
        end else begin
          esc_nxt  = 1'b0;
          br_nxt   = 1'b0;
          consumed = stream_r;
        end
      end else begin
        consumed = 1'b1;
        if (b >= CH_FINAL_LO && b <= CH_FINAL_HI) begin
          esc_nxt = 1'b0;
          br_nxt  = 1'b0;
        end
      end

      if (!consumed) begin
        if (stream_r) begin
          // Only q on an empty line leaves stream mode
          if ((b == CH_LOWER_Q || b == CH_UPPER_Q) && len_r == '0) begin
            stream_nxt = 1'b0;
            esc_nxt    = 1'b0;
            br_nxt     = 1'b0;
            plan       = PL_NL_STOP;
          end
        end else if (b == CH_CR || (b == CH_LF && !prev_cr_r)) begin
          // Line end
          len_nxt     = '0;
          dropped_nxt = 1'b0;
          prev_cr_nxt = (b == CH_CR);
          if (!dropped_r && len_r != '0) begin
            dlen_nxt  = len_r;
            await_nxt = 1'b1;
            plan      = PL_NL_DELIV;
          end else begin
            plan = PL_NL_PROMPT;
          end
        end else if (b == CH_LF) begin
          // Second half of CR LF
          prev_cr_nxt = 1'b0;
        end else begin
          prev_cr_nxt = 1'b0;
          if (b == CH_BS || b == CH_DEL) begin
            if (len_r != '0 && !dropped_r) begin
              len_nxt = len_r - 1'b1;
              plan    = PL_ERASE;
            end
          end else if (b >= CH_PRINT_LO && b <= CH_PRINT_HI && !dropped_r) begin
            if (len_r >= LEN_W'(MAX_LINE)) begin
              dropped_nxt = 1'b1;
            end else begin
              wr_en   = 1'b1;
              len_nxt = len_r + 1'b1;
              plan    = PL_ECHO;
            end
          end
        end
      end
    end
  end

  // Control state, updated on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_r  <= 1'b0;
      esc_r     <= 1'b0;
      br_r      <= 1'b0;
      prev_cr_r <= 1'b0;
      dropped_r <= 1'b0;
      await_r   <= 1'b0;
      len_r     <= '0;
    end else if (cmd.take) begin
      stream_r  <= stream_nxt;
      esc_r     <= esc_nxt;
      br_r      <= br_nxt;
      prev_cr_r <= prev_cr_nxt;
      dropped_r <= dropped_nxt;
      await_r   <= await_nxt;
      len_r     <= len_nxt;
    end
  end

  // Item payload and delivery length
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      echo_ch_r <= b[6:0];
      dlen_r    <= dlen_nxt;
    end
  end

  // Delivery index: clear on transfer, step per sent character
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd_idx_r <= '0;
    end else if (cmd.advance) begin
      rd_idx_r <= rd_idx_r + 1'b1;
    end
  end

  // Line store: write on echo, registered read for delivery
  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) begin
      line_mem[len_r[IDX_W-1:0]] <= b[6:0];
    end
    if (cmd.rd) begin
      rdata_r <= line_mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit && out_free) begin
      out_r.kind <= cmd.kind;
      out_r.last <= cmd.last;
      case (cmd.kind)
        K_ECHO:     out_r.char_out <= echo_ch_r;
        K_LINECHAR: out_r.char_out <= rdata_r;
        default:    out_r.char_out <= '0;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_r;
  assign stat.plan      = plan;
  assign stat.out_free  = out_free;
  assign stat.last_char = (LEN_W'(rd_idx_r + 1'b1) == dlen_r);

endmodule

// File: sv/tle_checker.sv
// tle_checker: port-level assertions for terminal_line_editor, with bind.
// Depends on tle_pkg; sees only the top level's ports.
module tle_checker import tle_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input tle_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input tle_out_t out_data
);

  // Hold a stalled input item
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input item changed");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Zero the character on kinds that carry none
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != K_ECHO && out_data.kind != K_LINECHAR
    |-> out_data.char_out == 7'd0)
    else $error("character on a kind without one");

  // Newline and stop notice always lead into more results
  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == K_NEWLINE || out_data.kind == K_STOPPED)
    |-> !out_data.last)
    else $error("newline or stop notice marked last");

  // Single results always close their run
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == K_ECHO || out_data.kind == K_ERASE ||
                  out_data.kind == K_PROMPT)
    |-> out_data.last)
    else $error("echo, erase or prompt not marked last");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
